[hw/rtl/imtk_pkg.sv]
// Shared types, constants and the per-byte token rule for the IRC message tokenizer.
// No dependencies; imported by every module of the block.
package imtk_pkg;

  localparam int MAX_TOKEN_LEN = 512;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int CNT_W         = 4;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int FILL_W        = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] BYTE_CR       = 8'd13;
  localparam logic [7:0] BYTE_LF       = 8'd10;
  localparam logic [7:0] SEP_RESET     = 8'd32;  // space
  localparam logic [7:0] MARKER_RESET  = 8'd58;  // colon
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;

  // parse modes
  localparam logic [1:0] MODE_BETWEEN  = 2'd0;
  localparam logic [1:0] MODE_TOKEN    = 2'd1;
  localparam logic [1:0] MODE_TRAILING = 2'd2;

  // configuration register indexes
  localparam logic REG_SEPARATOR = 1'b0;
  localparam logic REG_MARKER    = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic             cr_pending;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] count;
  } state_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             token_done;
    logic [LEN_W-1:0] token_length;
    logic [CNT_W-1:0] token_number;
    logic             is_trailing;
    logic             message_done;
    logic             last;
  } result_t;

  typedef struct packed {
    state_t  st;
    result_t res;
    logic    emit;
  } step_t;

  function automatic logic [LEN_W-1:0] grow_length(logic [LEN_W-1:0] len);
    return (len < LEN_W'(MAX_TOKEN_LEN)) ? len + LEN_W'(1) : len;
  endfunction

  function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] cnt);
    return (cnt < COUNT_TOP) ? cnt + CNT_W'(1) : cnt;
  endfunction

  // Handle one ordinary byte (never a CR that is to be held).
  function automatic step_t plain_byte(state_t s, logic [7:0] b,
                                       logic [7:0] sep, logic [7:0] mark);
    step_t r;
    r      = '0;
    r.st   = s;
    r.res.token_number = s.count;
    case (s.mode)
      MODE_TRAILING: begin
        r.st.length        = grow_length(s.length);
        r.res.out_byte     = b;
        r.res.byte_valid   = 1'b1;
        r.res.is_trailing  = 1'b1;
        r.emit             = 1'b1;
      end
      MODE_TOKEN: begin
        if (b == sep) begin
          r.res.token_done   = 1'b1;
          r.res.token_length = s.length;
          r.st.length        = '0;
          r.st.count         = bump_count(s.count);
          r.st.mode          = MODE_BETWEEN;
        end else begin
          r.st.length      = grow_length(s.length);
          r.res.out_byte   = b;
          r.res.byte_valid = 1'b1;
        end
        r.emit = 1'b1;
      end
      default: begin
        // between tokens: skip separators, drop a leading marker
        if (b != sep) begin
          r.st.length = '0;
          if (b == mark) begin
            r.st.mode = MODE_TRAILING;
          end else begin
            r.st.mode        = MODE_TOKEN;
            r.st.length      = grow_length('0);
            r.res.out_byte   = b;
            r.res.byte_valid = 1'b1;
            r.emit           = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/imtk_step.sv]
// Parser state register and the combinational per-byte step (up to two results).
// Depends on imtk_pkg.
module imtk_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [7:0]          in_byte,
  input  logic [7:0]          sep,
  input  logic [7:0]          mark,
  output imtk_pkg::result_t   res0,
  output imtk_pkg::result_t   res1,
  output logic [1:0]          push_n
);
  import imtk_pkg::*;

  state_t  state;
  state_t  state_next;
  state_t  s1;
  step_t   cr_step;
  step_t   byte_step;
  result_t msg_res;
  logic    msg_close;

  always_comb begin
    s1            = state;
    s1.cr_pending = 1'b0;
    cr_step       = '0;
    byte_step     = '0;
    msg_res       = '0;
    msg_close     = 1'b0;
    state_next    = state;

    if (state.cr_pending && in_byte == BYTE_LF) begin
      // CR LF: close the token and the message
      msg_close            = 1'b1;
      msg_res.token_done   = 1'b1;
      msg_res.token_length = state.length;
      msg_res.token_number = state.count;
      msg_res.is_trailing  = (state.mode == MODE_TRAILING);
      msg_res.message_done = 1'b1;
      msg_res.last         = 1'b1;
      state_next           = '0;
      state_next.mode      = MODE_BETWEEN;
    end else begin
      if (state.cr_pending) begin
        // held CR turned out to be an ordinary byte
        cr_step = plain_byte(s1, BYTE_CR, sep, mark);
        s1      = cr_step.st;
      end
      if (in_byte == BYTE_CR) begin
        state_next            = s1;
        state_next.cr_pending = 1'b1;
      end else begin
        byte_step  = plain_byte(s1, in_byte, sep, mark);
        state_next = byte_step.st;
      end
    end
  end

  always_comb begin
    res0   = '0;
    res1   = '0;
    push_n = 2'd0;
    if (msg_close) begin
      res0   = msg_res;
      push_n = 2'd1;
    end else if (cr_step.emit && byte_step.emit) begin
      res0      = cr_step.res;
      res1      = byte_step.res;
      res1.last = 1'b1;
      push_n    = 2'd2;
    end else if (cr_step.emit) begin
      res0      = cr_step.res;
      res0.last = 1'b1;
      push_n    = 2'd1;
    end else if (byte_step.emit) begin
      res0      = byte_step.res;
      res0.last = 1'b1;
      push_n    = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_BETWEEN, cr_pending: 1'b0, length: '0, count: '0};
    end else if (en) begin
      state <= state_next;
    end
  end

endmodule

[hw/rtl/imtk_res_fifo.sv]
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on imtk_pkg.
module imtk_res_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  push_n,
  input  imtk_pkg::result_t           din0,
  input  imtk_pkg::result_t           din1,
  input  logic                        pop,
  output imtk_pkg::result_t           head,
  output logic                        not_empty,
  output logic [imtk_pkg::FILL_W-1:0] fill
);
  import imtk_pkg::*;

  result_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic               do_pop;

  assign not_empty = (fill != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push_n) - FILL_W'(do_pop);
    end
  end

endmodule

[hw/rtl/irc_message_tokenizer.sv]
// Top level of the IRC message tokenizer: input register, config registers,
// parser step and result queue. Depends on imtk_pkg, imtk_step, imtk_res_fifo.
//
// Usage:
//   Raw message bytes enter on the s_ channel, one byte per transfer.
//   Each byte yields zero, one or two results on the m_ channel; m_tlast
//   marks the last result a byte caused. A byte that yields nothing (a
//   skipped separator, a dropped trailing marker, a held CR) leaves no trace.
//   The two separator/marker bytes are set through cfg_we/cfg_index/cfg_data
//   while the block is idle; reset loads space and colon.
//   Order: a taken byte waits in the input register until it is parsed;
//   its results then enter the result queue and transfer from it in order.
//   Throughput: one byte per cycle while m_tready stays high and each byte
//   yields at most one result; the single-entry parse stage and the four-entry
//   result queue set this: a byte is parsed only when two queue slots are free.
//   When the receiver stalls, results collect in the queue, then the input
//   register holds its byte and s_tready drops; nothing is lost.
//   Reset (rst, synchronous) empties the queue and returns the parser to
//   "between tokens, token 0, no CR held".
module irc_message_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] out_byte, [8] byte_valid, [9] token_done,
                                 // [19:10] token_length, [23:20] token_number,
                                 // [24] is_trailing, [25] message_done, rest zero
  output logic        m_tlast    // last
);
  import imtk_pkg::*;

  logic [7:0]        separator_char;
  logic [7:0]        trailing_marker;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic              room;
  logic              advance;
  logic [1:0]        push_n;
  logic [1:0]        push_gated;
  result_t           res0;
  result_t           res1;
  result_t           head;
  logic [FILL_W-1:0] fill;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char  <= SEP_RESET;
      trailing_marker <= MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEPARATOR: separator_char  <= cfg_data;
        REG_MARKER:    trailing_marker <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Parse the held byte only when the queue can take two results
  assign room     = (fill <= FILL_W'(FIFO_DEPTH - 2));
  assign advance  = in_valid && room;
  assign s_tready = !in_valid || room;

  // Input register: hold the byte until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  imtk_step u_step (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .in_byte (in_byte),
    .sep     (separator_char),
    .mark    (trailing_marker),
    .res0    (res0),
    .res1    (res1),
    .push_n  (push_n)
  );

  // Drop the push when no byte is being parsed this cycle
  assign push_gated = advance ? push_n : 2'd0;

  imtk_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_gated),
    .din0      (res0),
    .din1      (res1),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .fill      (fill)
  );

  assign m_tdata = {6'd0, head.message_done, head.is_trailing, head.token_number,
                    head.token_length, head.token_done, head.byte_valid, head.out_byte};
  assign m_tlast = head.last;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && head.message_done) |-> (head.last && head.token_done))
    else $error("message close not the last result of its byte");

  a_len_only_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !head.token_done) |-> (head.token_length == '0))
    else $error("token length outside token end");

  a_byte_xor_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(head.byte_valid && head.token_done))
    else $error("token byte and token end in one result");

endmodule

[sim/testbench.sv]
// Self-checking testbench for irc_message_tokenizer: streams byte traffic into the
// tokenizer, predicts every token result and compares each output transfer field by field.
// Depends on imtk_pkg (modes, byte codes, register indexes) and the tokenizer RTL.
module testbench;
  import imtk_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 12;

  // one predicted output transfer
  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             token_done;
    logic [LEN_W-1:0] token_length;
    logic [CNT_W-1:0] token_number;
    logic             is_trailing;
    logic             message_done;
    logic             last;
  } tok_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_SEPARATOR;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [7:0] out_byte, [8] byte_valid, [9] token_done,
                                 // [19:10] token_length, [23:20] token_number,
                                 // [24] is_trailing, [25] message_done, rest zero
  logic        m_tlast;          // last

  irc_message_tokenizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Stimulus and scoreboard storage
  logic [7:0] byte_q[$];      // bytes waiting for the driver
  tok_res_t   token_q[$];     // predicted results, oldest first
  int         queued_cnt   = 0;
  int         accepted_cnt = 0;
  int         errors       = 0;
  int         cycle_cnt    = 0;

  // Tokenizer shadow state and register copies
  logic [1:0]       mode    = MODE_BETWEEN;
  logic             cr_held = 1'b0;
  logic [LEN_W-1:0] cur_len = '0;
  logic [CNT_W-1:0] tok_cnt = '0;
  logic [7:0]       tok_sep  = SEP_RESET;
  logic [7:0]       tok_mark = MARKER_RESET;

  // Handle one ordinary byte: anything except a CR that is about to be held.
  task automatic tok_plain(input logic [7:0] b, output logic emit, output tok_res_t r);
    r = '0;
    emit = 1'b0;
    r.token_number = tok_cnt;
    case (mode)
      MODE_TRAILING: begin
        // trailing parameter swallows everything, separators included
        if (cur_len < MAX_TOKEN_LEN) cur_len = cur_len + 1'b1;
        r.out_byte    = b;
        r.byte_valid  = 1'b1;
        r.is_trailing = 1'b1;
        emit          = 1'b1;
      end
      MODE_TOKEN: begin
        emit = 1'b1;
        if (b == tok_sep) begin
          // separator closes the token with no byte of its own
          r.token_done   = 1'b1;
          r.token_length = cur_len;
          cur_len        = '0;
          if (tok_cnt != COUNT_TOP) tok_cnt = tok_cnt + 1'b1;
          mode           = MODE_BETWEEN;
        end else begin
          if (cur_len < MAX_TOKEN_LEN) cur_len = cur_len + 1'b1;
          r.out_byte   = b;
          r.byte_valid = 1'b1;
        end
      end
      default: begin
        // between tokens: skip separator runs, drop a leading marker
        if (b != tok_sep) begin
          cur_len = '0;
          if (b == tok_mark) begin
            mode = MODE_TRAILING;
          end else begin
            mode         = MODE_TOKEN;
            cur_len      = LEN_W'(1);
            r.out_byte   = b;
            r.byte_valid = 1'b1;
            emit         = 1'b1;
          end
        end
      end
    endcase
  endtask

  // Predict the results of one accepted byte and queue them.
  task automatic tok_predict(input logic [7:0] b);
    tok_res_t r0, r1;
    logic     e0, e1;
    e0 = 1'b0;
    e1 = 1'b0;
    r0 = '0;
    r1 = '0;
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == BYTE_LF) begin
        // CR LF closes the current (possibly empty) token and the message
        r0.token_done   = 1'b1;
        r0.token_length = cur_len;
        r0.token_number = tok_cnt;
        r0.is_trailing  = (mode == MODE_TRAILING);
        r0.message_done = 1'b1;
        r0.last         = 1'b1;
        mode    = MODE_BETWEEN;
        cur_len = '0;
        tok_cnt = '0;
        token_q.push_back(r0);
        return;
      end
      // held CR turned out to be an ordinary byte
      tok_plain(BYTE_CR, e0, r0);
    end
    if (b == BYTE_CR) cr_held = 1'b1;
    else tok_plain(b, e1, r1);
    if (e0 && e1) begin
      token_q.push_back(r0);
      r1.last = 1'b1;
      token_q.push_back(r1);
    end else if (e0) begin
      r0.last = 1'b1;
      token_q.push_back(r0);
    end else if (e1) begin
      r1.last = 1'b1;
      token_q.push_back(r1);
    end
  endtask

  // Driver: bursts of transfers with random gaps, predicting at each accept.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        tok_predict(s_tdata);
        accepted_cnt++;
      end
      // advance only when the current transfer is done or none is offered
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1, 2:    gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 20);
            endcase
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transfer with the oldest prediction.
  tok_res_t exp_res;
  int       rx_tick = 0;
  int       rx_mode = 0;
  int       rx_per  = 4;
  int       rx_duty = 2;

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $error("result with no prediction waiting: tdata %h tlast %b", m_tdata, m_tlast);
          errors++;
        end else begin
          exp_res = token_q.pop_front();
          check_field("out_byte",     exp_res.out_byte,     m_tdata[7:0]);
          check_field("byte_valid",   exp_res.byte_valid,   m_tdata[8]);
          check_field("token_done",   exp_res.token_done,   m_tdata[9]);
          check_field("token_length", exp_res.token_length, m_tdata[19:10]);
          check_field("token_number", exp_res.token_number, m_tdata[23:20]);
          check_field("is_trailing",  exp_res.is_trailing,  m_tdata[24]);
          check_field("message_done", exp_res.message_done, m_tdata[25]);
          check_field("padding",      0,                    m_tdata[31:26]);
          check_field("last",         exp_res.last,         m_tlast);
        end
      end
      // receiver stall pattern: mode, period and duty are re-picked at random
      rx_tick++;
      if ((rx_tick % 256) == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_per  = $urandom_range(2, 9);
        rx_duty = $urandom_range(1, rx_per - 1);
      end
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ((rx_tick % rx_per) < rx_duty);
        2:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus helpers
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back(b);
    queued_cnt++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_seps();
    repeat ($urandom_range(1, 3)) push_byte(tok_sep);
  endtask

  // token byte: never a separator or CR; a first byte also avoids the marker
  function automatic logic [7:0] tok_char(input bit first);
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255));
    while (r == tok_sep || r == BYTE_CR || (first && r == tok_mark));
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0:       return BYTE_CR;
      1:       return BYTE_LF;
      2:       return tok_sep;
      3:       return tok_mark;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One message: tokens, optional trailing parameter, usually CR LF at the end.
  task automatic gen_message(input bit long_tok);
    int         ntok, len;
    bit         trail;
    logic [7:0] b;
    ntok  = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 5);
    trail = $urandom_range(0, 1);
    if ($urandom_range(0, 3) == 0) push_seps();
    for (int i = 0; i < ntok; i++) begin
      len = (long_tok && i == 0) ? $urandom_range(MAX_TOKEN_LEN + 1, MAX_TOKEN_LEN + 18)
                                 : $urandom_range(1, 8);
      push_byte(tok_char(1'b1));
      for (int j = 1; j < len; j++) push_byte(tok_char(1'b0));
      // a separator before CR LF leaves an empty final token
      if (i != ntok - 1 || trail || $urandom_range(0, 3) == 0) push_seps();
    end
    if (trail) begin
      push_byte(tok_mark);
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 15) == 0) begin
          // CR inside the trailing parameter that is not followed by LF
          push_byte(BYTE_CR);
          do b = 8'($urandom_range(0, 255));
          while (b == BYTE_CR || b == BYTE_LF);
          push_byte(b);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b == BYTE_CR);
          push_byte(b);
        end
      end
    end
    // now and then leave the message open
    if ($urandom_range(0, 9) != 0) begin
      push_byte(BYTE_CR);
      push_byte(BYTE_LF);
    end
  endtask

  task automatic rand_phase(input int n, input bit long_tok);
    int start;
    start = queued_cnt;
    if (long_tok) gen_message(1'b1);
    while (queued_cnt - start < n) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 8)) push_byte(noise_byte());
      else gen_message(1'b0);
    end
  endtask

  // Wait until every byte is taken and every result has come, then let the
  // pipeline settle, since a held CR or a skipped byte leaves no result.
  task automatic drain();
    while (accepted_cnt != queued_cnt || token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic cfg_write(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEPARATOR) tok_sep = v;
    else tok_mark = v;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with reset registers (space, colon).
    // Extreme bytes and a marker inside a plain token.
    push_byte(8'd0);
    push_byte(8'd255);
    push_str("a:b");
    // separator ends a token, then a separator run is skipped
    push_str("  ");
    // lone LF starts a token; CR followed by a plain byte is flushed
    push_byte(BYTE_LF);
    push_byte(BYTE_CR);
    push_str("q");
    // separator then CR LF: empty final token
    push_str(" ");
    push_byte(BYTE_CR);
    push_byte(BYTE_LF);
    // trailing parameter with a space inside, a CR CR pair, then CR LF
    push_str(":x y");
    push_byte(BYTE_CR);
    push_byte(BYTE_CR);
    push_byte(BYTE_LF);
    // empty trailing parameter
    push_str(":");
    push_byte(BYTE_CR);
    push_byte(BYTE_LF);
    drain();

    // Random traffic across several register settings, extremes included.
    cfg_write(REG_SEPARATOR, SEP_RESET);
    cfg_write(REG_MARKER, MARKER_RESET);
    rand_phase(260, 1'b1);
    drain();

    cfg_write(REG_SEPARATOR, 8'd0);
    cfg_write(REG_MARKER, 8'd255);
    rand_phase(180, 1'b0);
    drain();

    cfg_write(REG_SEPARATOR, 8'd255);
    cfg_write(REG_MARKER, 8'd0);
    rand_phase(180, 1'b0);
    drain();

    // register bytes equal to CR and LF: CR still takes priority
    cfg_write(REG_SEPARATOR, BYTE_CR);
    cfg_write(REG_MARKER, BYTE_LF);
    rand_phase(180, 1'b0);
    drain();

    // same byte for both: the separator test wins between tokens
    cfg_write(REG_SEPARATOR, 8'd120);
    cfg_write(REG_MARKER, 8'd120);
    rand_phase(180, 1'b0);
    drain();

    cfg_write(REG_SEPARATOR, SEP_RESET);
    cfg_write(REG_MARKER, MARKER_RESET);
    rand_phase(180, 1'b0);
    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
